// File: src/sensor_scan_decoder_history_defines.svh
// assertion macros for the sensor scan decoder history checker
// no dependencies; taken in by the checker file only
`ifndef SENSOR_SCAN_DECODER_HISTORY_DEFINES_SVH
`define SENSOR_SCAN_DECODER_HISTORY_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define SSDH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define SSDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ssdh_pkg.sv
// shared constants and types of the sensor scan decoder history block
// no dependencies
package ssdh_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int MODULE_COUNT  = 5;

	localparam int BYTE_W    = 8;
	localparam int MOD_W     = 4;
	localparam int SENSOR_W  = 4;
	localparam int COUNT_W   = 4;
	localparam int BIT_IDX_W = 3;
	localparam int ID_W      = MOD_W + SENSOR_W;

	localparam logic [SENSOR_W-1:0]  HALF_OFFSET = 4'h8;
	localparam logic [BIT_IDX_W-1:0] BIT_MAX     = 3'd7;
	localparam logic [COUNT_W-1:0]   COUNT_MAX   = COUNT_W'(HISTORY_DEPTH);
	localparam logic [MOD_W-1:0]     MODULE_LAST = MOD_W'(MODULE_COUNT - 1);

	// one classified poll byte on its way to the back end
	typedef struct packed {
		logic [BYTE_W-1:0] bits;
		logic [MOD_W-1:0]  module_idx;
		logic              high_half;
	} item_t;

	// one recorded sensor id
	typedef struct packed {
		logic [MOD_W-1:0]    module_index;
		logic [SENSOR_W-1:0] sensor_index;
		logic [COUNT_W-1:0]  history_count;
		logic                last_of_run;
	} result_t;

endpackage

// File: src/ssdh_front.sv
// front end: tracks the poll position and tags each byte with module and half
// depends on ssdh_pkg
module ssdh_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [ssdh_pkg::BYTE_W-1:0] poll_byte,
	output logic                      full,
	input  logic                      q_full,
	output logic                      q_push,
	output ssdh_pkg::item_t           q_item
);

	logic [ssdh_pkg::MOD_W-1:0] poll_module_q;
	logic                       poll_high_q;
	logic                       accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	// bytes with no set bit only move the poll position
	assign q_push            = accept && (poll_byte != '0);
	assign q_item.bits       = poll_byte;
	assign q_item.module_idx = poll_module_q;
	assign q_item.high_half  = poll_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_module_q <= '0;
			poll_high_q   <= 1'b0;
		end else if (accept) begin
			poll_high_q <= !poll_high_q;
			if (poll_high_q) begin
				if (poll_module_q == ssdh_pkg::MODULE_LAST) begin
					poll_module_q <= '0;
				end else begin
					poll_module_q <= poll_module_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: src/ssdh_item_queue.sv
// two-entry queue of classified bytes between front and back end
// depends on ssdh_pkg
module ssdh_item_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssdh_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ssdh_pkg::item_t rd_item
);

	ssdh_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/ssdh_back.sv
// back end: walks a byte's set bits one per cycle unless stalled, drops a
// repeat of the latest id, saturates the history count; depends on ssdh_pkg
module ssdh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  ssdh_pkg::item_t   q_item,
	output logic              q_pop,
	input  logic              out_space,
	output logic              res_valid,
	output ssdh_pkg::result_t res
);

	logic [ssdh_pkg::BYTE_W-1:0]    mask_q;
	logic [ssdh_pkg::MOD_W-1:0]     module_q;
	logic                           high_q;
	logic [ssdh_pkg::ID_W-1:0]      last_id_q;
	logic [ssdh_pkg::COUNT_W-1:0]   count_q;

	logic                           busy;
	logic                           step;
	logic                           dup;
	logic [ssdh_pkg::BIT_IDX_W-1:0] low_idx;
	logic [ssdh_pkg::BYTE_W-1:0]    rest;
	logic [ssdh_pkg::SENSOR_W-1:0]  sensor;
	logic [ssdh_pkg::ID_W-1:0]      id;
	logic [ssdh_pkg::COUNT_W-1:0]   count_next;

	// lowest set bit goes first
	always_comb begin
		low_idx = '0;
		for (int i = ssdh_pkg::BYTE_W - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = ssdh_pkg::BIT_IDX_W'(i);
			end
		end
	end

	assign busy   = (mask_q != '0);
	assign rest   = mask_q & (mask_q - 1'b1);
	assign sensor = (high_q ? ssdh_pkg::HALF_OFFSET : '0)
		| {1'b0, ssdh_pkg::BIT_MAX - low_idx};
	assign id     = {module_q, sensor};
	assign dup    = (count_q != '0) && (id == last_id_q);
	assign step   = busy && out_space;

	assign count_next = (count_q == ssdh_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	assign res_valid         = step && !dup;
	assign res.module_index  = module_q;
	assign res.sensor_index  = sensor;
	assign res.history_count = count_next;
	assign res.last_of_run   = (rest == '0);

	// next byte loads as the current one finishes
	assign q_pop = q_valid && (!busy || (step && rest == '0));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			module_q <= q_item.module_idx;
			high_q   <= q_item.high_half;
		end
		if (res_valid) begin
			last_id_q <= id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			count_q <= '0;
		end else begin
			if (q_pop) begin
				mask_q <= q_item.bits;
			end else if (step) begin
				mask_q <= rest;
			end
			if (res_valid) begin
				count_q <= count_next;
			end
		end
	end

endmodule

// File: src/ssdh_result_queue.sv
// two-entry result queue that drives the output ports
// depends on ssdh_pkg
module ssdh_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ssdh_pkg::result_t wr_res,
	output logic              space,
	input  logic              pop,
	output logic              empty,
	output ssdh_pkg::result_t rd_res
);

	ssdh_pkg::result_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == 2'd0);
	assign do_pop  = pop && !empty;
	assign space   = (count_q != 2'd2) || do_pop;
	assign do_push = push && space;
	assign rd_res  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/sensor_scan_decoder_history.sv
// top level of the sensor scan decoder with recent-sensor history
// depends on ssdh_pkg, ssdh_front, ssdh_item_queue, ssdh_back, ssdh_result_queue
//
// poll response bytes enter through a queue-style push/full port, two bytes
// per module (low half, then high half), modules 0 to MODULE_COUNT-1 in turn
// with wrap. every set bit, lowest bit first, names a sensor id; an id equal
// to the latest recorded one is dropped, every other id is recorded and comes
// out as one transaction on the empty/pop side with the history fill count
// (saturating at HISTORY_DEPTH) and a last_of_run mark on the final id of its
// byte. the back end walks a byte's set bits (1 to 8) one after another,
// holding while the result queue has no space; zero bytes skip it; it
// loads the next byte in the cycle the current one finishes. a two-entry
// queue between front and back and a two-entry result queue let input and
// output stall independently. there is no clearing pass after reset
module sensor_scan_decoder_history (
	input  logic                          clk,
	input  logic                          arst_n,
	// input side
	input  logic                          push,
	input  logic [ssdh_pkg::BYTE_W-1:0]   poll_byte,
	output logic                          full,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic [ssdh_pkg::MOD_W-1:0]    module_index,
	output logic [ssdh_pkg::SENSOR_W-1:0] sensor_index,
	output logic [ssdh_pkg::COUNT_W-1:0]  history_count,
	output logic                          last_of_run
);

	// front to item queue
	logic              fq_push;
	ssdh_pkg::item_t   fq_item;
	logic              fq_full;
	// item queue to back end
	logic              qb_empty;
	logic              qb_pop;
	ssdh_pkg::item_t   qb_item;
	// back end to result queue
	logic              br_valid;
	ssdh_pkg::result_t br_res;
	logic              br_space;
	// result queue head
	ssdh_pkg::result_t head;

	// tags bytes with the poll position and drops zero bytes
	ssdh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.poll_byte (poll_byte),
		.full      (full),
		.q_full    (fq_full),
		.q_push    (fq_push),
		.q_item    (fq_item)
	);

	// decouples input acceptance from bit walking
	ssdh_item_queue u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.wr_item (fq_item),
		.full    (fq_full),
		.pop     (qb_pop),
		.empty   (qb_empty),
		.rd_item (qb_item)
	);

	// one set bit per cycle unless stalled, repeat filter and history count
	ssdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!qb_empty),
		.q_item    (qb_item),
		.q_pop     (qb_pop),
		.out_space (br_space),
		.res_valid (br_valid),
		.res       (br_res)
	);

	// output buffering so a stalled consumer does not block the walker at once
	ssdh_result_queue u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (br_valid),
		.wr_res (br_res),
		.space  (br_space),
		.pop    (pop),
		.empty  (empty),
		.rd_res (head)
	);

	assign module_index  = head.module_index;
	assign sensor_index  = head.sensor_index;
	assign history_count = head.history_count;
	assign last_of_run   = head.last_of_run;

endmodule

// File: src/sensor_scan_decoder_history_checker.sv
// port-level checker for the sensor scan decoder history block and its bind
// depends on ssdh_pkg and sensor_scan_decoder_history_defines.svh
`include "sensor_scan_decoder_history_defines.svh"

module sensor_scan_decoder_history_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [ssdh_pkg::MOD_W-1:0]    module_index,
	input logic [ssdh_pkg::SENSOR_W-1:0] sensor_index,
	input logic [ssdh_pkg::COUNT_W-1:0]  history_count,
	input logic                          last_of_run
);

	logic count_ok;

	assign count_ok = (history_count != '0) && (history_count <= ssdh_pkg::COUNT_MAX);

	// a shown result always has a count in range
	`SSDH_ASSERT_NOW(a_count_range, clk, arst_n, !empty, count_ok, "history_count out of range")

	// module of a result is a polled module
	`SSDH_ASSERT_NOW(a_module_range, clk, arst_n, !empty,
		module_index <= ssdh_pkg::MODULE_LAST, "module_index beyond module count")

	// history count never goes down from one result to the next
	`SSDH_ASSERT_NEXT(a_count_monotonic, clk, arst_n, !empty && pop,
		empty || (history_count >= $past(history_count)), "history_count decreased")

	// a stalled result holds
	`SSDH_ASSERT_NEXT(a_stall_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(module_index) && $stable(sensor_index)
		&& $stable(history_count) && $stable(last_of_run), "stalled result changed")

endmodule

bind sensor_scan_decoder_history sensor_scan_decoder_history_checker u_checker (.*);

// File: tb/sensor_scan_decoder_history_tb.sv
// self-checking testbench for sensor_scan_decoder_history
// depends on ssdh_pkg and the sensor_scan_decoder_history rtl; an in-file scoreboard
// predicts every recorded sensor id and checks the result transactions in order
module sensor_scan_decoder_history_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssdh_pkg::*;

	localparam int POLL_SLOTS = 2 * MODULE_COUNT;  // bytes in one full poll cycle
	localparam int ITEM_GOAL  = 430;
	localparam int HOLD_CYCLES = 300;             // long receiver hold-off
	localparam int DRAIN_CYCLES = 16;

	// tracks the poll position and the recent-sensor history, and holds
	// the ids that are still due on the result side
	class sensor_id_scoreboard;
		logic [MOD_W-1:0]   cur_module;
		logic               cur_high;
		logic [ID_W-1:0]    ring [HISTORY_DEPTH];
		logic [COUNT_W-1:0] wr_slot;
		logic [COUNT_W-1:0] fill;
		result_t            expected_ids [$];
		int                 mismatches;

		function new();
			cur_module = '0;
			cur_high   = 1'b0;
			wr_slot    = '0;
			fill       = '0;
			mismatches = 0;
		endfunction

		// one accepted poll byte: decode its set bits into new ids
		function void record_poll_byte(logic [BYTE_W-1:0] b);
			logic [MOD_W-1:0]    mod_now;
			logic                high_now;
			logic [SENSOR_W-1:0] sensor;
			logic [ID_W-1:0]     id;
			logic [COUNT_W-1:0]  prev;
			result_t             r;
			int                  first;
			mod_now  = cur_module;
			high_now = cur_high;
			// low half, then high half, then on to the next module
			if (!cur_high) begin
				cur_high = 1'b1;
			end else begin
				cur_module = (cur_module == MODULE_LAST) ? '0 : cur_module + 1'b1;
				cur_high   = 1'b0;
			end
			first = expected_ids.size();
			for (int i = 0; i < BYTE_W; i++) begin
				if (!b[i])
					continue;
				sensor = (high_now ? HALF_OFFSET : '0) | SENSOR_W'(BIT_MAX - BIT_IDX_W'(i));
				id = {mod_now, sensor};
				// repeat of the latest recorded id is dropped
				if (fill != 0) begin
					prev = (wr_slot == 0) ? COUNT_W'(HISTORY_DEPTH - 1) : wr_slot - 1'b1;
					if (ring[prev] == id)
						continue;
				end
				ring[wr_slot] = id;
				wr_slot = (wr_slot == COUNT_W'(HISTORY_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
				if (fill < COUNT_MAX)
					fill = fill + 1'b1;
				r.module_index  = mod_now;
				r.sensor_index  = sensor;
				r.history_count = fill;
				r.last_of_run   = 1'b0;
				expected_ids.push_back(r);
			end
			if (expected_ids.size() > first)
				expected_ids[expected_ids.size() - 1].last_of_run = 1'b1;
		endfunction

		function int pending();
			return expected_ids.size();
		endfunction

		// one popped result against the oldest expected id
		function void check_id(result_t got);
			result_t exp_id;
			bit      bad;
			if (expected_ids.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: module %0d sensor %0d count %0d last %0b",
						got.module_index, got.sensor_index, got.history_count,
						got.last_of_run);
				return;
			end
			exp_id = expected_ids.pop_front();
			bad = (got.module_index != exp_id.module_index)
				|| (got.sensor_index != exp_id.sensor_index)
				|| (got.history_count != exp_id.history_count)
				|| (got.last_of_run != exp_id.last_of_run);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display(
						"mismatch: module %0d/%0d sensor %0d/%0d count %0d/%0d last %0b/%0b (exp/got)",
						exp_id.module_index, got.module_index,
						exp_id.sensor_index, got.sensor_index,
						exp_id.history_count, got.history_count,
						exp_id.last_of_run, got.last_of_run);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic [BYTE_W-1:0]   poll_byte = '0;
	logic                full;
	logic                empty;
	logic                pop = 1'b0;
	logic [MOD_W-1:0]    module_index;
	logic [SENSOR_W-1:0] sensor_index;
	logic [COUNT_W-1:0]  history_count;
	logic                last_of_run;

	sensor_id_scoreboard sb = new();

	bit quiet = 1'b0;      // both sides run without idle cycles while set
	bit hold_req = 1'b0;   // asks the result side for one long hold-off
	int slot = 0;          // position of the next byte within the poll cycle
	int sent = 0;

	sensor_scan_decoder_history dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.poll_byte(poll_byte),
		.full(full),
		.empty(empty),
		.pop(pop),
		.module_index(module_index),
		.sensor_index(sensor_index),
		.history_count(history_count),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// offer one byte, at times with a random idle gap in front, and wait for the
	// transaction; push stays high into the next byte unless that one idles
	task automatic send_poll_byte(input logic [BYTE_W-1:0] b);
		if (!quiet && $urandom_range(0, 99) < 22) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		push <= 1'b1;
		poll_byte <= b;
		do @(posedge clk); while (full);
		sb.record_poll_byte(b);
		slot = (slot == POLL_SLOTS - 1) ? 0 : slot + 1;
		sent++;
	endtask

	// sender goes quiet until every expected id has been popped
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly sparse bytes so the history repeat rule gets exercised,
	// plus dense and fully random ones
	function automatic logic [BYTE_W-1:0] pick_poll_byte();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 35)
			return BYTE_W'($urandom_range(0, 255));
		else if (mode < 55)
			return '0;
		else if (mode < 85)
			return BYTE_W'(1) << $urandom_range(0, BYTE_W - 1);
		else if (mode < 93)
			return '1;
		else
			return BYTE_W'(3) << $urandom_range(0, BYTE_W - 2);
	endfunction

	// result side: random pop, plus one long hold-off on request
	initial begin : result_side
		int hold;
		result_t got;
		hold = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= quiet || ($urandom_range(0, 99) >= 22);
			end
			@(posedge clk);
			// outputs read here still hold their pre-edge values
			if (pop && !empty) begin
				got.module_index  = module_index;
				got.sensor_index  = sensor_index;
				got.history_count = history_count;
				got.last_of_run   = last_of_run;
				sb.check_id(got);
			end
		end
	end

	// overall limit, far above the slowest correct run
	initial begin : watchdog
		#3000000;
		$display("sensor_scan_decoder_history_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] frame_bits;
		int frame_pos;
		int frame_len;
		bit hold_done;
		bit drain_done;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one bit in slot 0, then a silent poll cycle: the same id comes
		// around again and must be dropped as a repeat
		send_poll_byte(8'h01);
		for (int i = 1; i < POLL_SLOTS; i++)
			send_poll_byte(8'h00);
		send_poll_byte(8'h01);
		// all-ones bytes fill the history past its depth, then odd patterns
		send_poll_byte(8'hFF);
		send_poll_byte(8'h80);
		send_poll_byte(8'hFF);
		send_poll_byte(8'h55);
		send_poll_byte(8'hAA);
		send_poll_byte(8'h00);
		send_poll_byte(8'hFF);
		send_poll_byte(8'h01);
		send_poll_byte(8'h80);
		drain_results();

		while (sent < ITEM_GOAL) begin
			// a stretch with no idling on either side
			quiet = (sent >= 120 && sent < 200);
			// long result hold-off while the sender keeps pushing
			if (sent >= 260 && !hold_done) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (sent >= 340 && !drain_done) begin
				drain_results();
				drain_done = 1'b1;
			end

			if ($urandom_range(0, 99) < 55) begin
				// replayed poll cycles: one byte, mostly single-bit, at a fixed slot,
				// zeros elsewhere, so the same id keeps coming back
				frame_pos  = $urandom_range(0, POLL_SLOTS - 1);
				frame_bits = BYTE_W'(1) << $urandom_range(0, BYTE_W - 1);
				if ($urandom_range(0, 3) == 0)
					frame_bits = pick_poll_byte();
				frame_len = $urandom_range(POLL_SLOTS, 3 * POLL_SLOTS);
				for (int i = 0; i < frame_len; i++) begin
					// occasional stray bits break the replay
					if ($urandom_range(0, 99) < 8)
						send_poll_byte(pick_poll_byte());
					else
						send_poll_byte((slot == frame_pos) ? frame_bits : '0);
				end
			end else begin
				for (int i = 0; i < POLL_SLOTS; i++)
					send_poll_byte(pick_poll_byte());
			end
		end
		quiet = 1'b0;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sensor_scan_decoder_history_tb: PASS");
		else
			$display("sensor_scan_decoder_history_tb: FAIL");
		$finish;
	end

endmodule
